FILE: hw/rtl/tst_pkg.sv
package tst_pkg;

  localparam int TIME_W = 48;
  localparam int DELAY_W = 32;
  localparam int SLOT_W = 4;

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] OP_FIRE     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_NO_TIMERS = 3'd3;
  localparam logic [2:0] ST_NONE_DUE  = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic [TIME_W-1:0]  now_ms;
    logic [DELAY_W-1:0] delay_ms;
    logic [SLOT_W-1:0]  slot_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] wait_ms;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic              active;
    logic [TIME_W-1:0] expiry;
  } slot_entry_t;

endpackage

FILE: hw/rtl/tst_cell.sv
module tst_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  tst_pkg::slot_entry_t d,
  output tst_pkg::slot_entry_t q
);

  logic                       active_r;
  logic [tst_pkg::TIME_W-1:0] expiry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (shift) begin
      active_r <= d.active;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      expiry_r <= d.expiry;
    end
  end

  assign q.active = active_r;
  assign q.expiry = expiry_r;

endmodule

FILE: hw/rtl/tst_seq.sv
module tst_seq #(
  parameter int SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tst_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tst_pkg::out_word_t   out_data,
  input  tst_pkg::slot_entry_t head,
  output tst_pkg::slot_entry_t tail,
  output logic                 shift
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMPW = (IW > tst_pkg::SLOT_W) ? IW : tst_pkg::SLOT_W;
  localparam logic [IW-1:0] LAST_STEP = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  logic [IW-1:0]                    cnt_r;
  logic [1:0]                       op_r;
  logic [tst_pkg::TIME_W-1:0]       now_r;
  logic [tst_pkg::TIME_W-1:0]       sum_r;
  logic [tst_pkg::SLOT_W-1:0]       idx_r;
  logic                             found_r;
  logic [tst_pkg::SLOT_W-1:0]       fslot_r;
  logic [tst_pkg::TIME_W-1:0]       min_r;
  logic                             pend_r;
  logic [tst_pkg::SLOT_W-1:0]       pslot_r;
  logic                             out_valid_r, out_valid_nxt;
  tst_pkg::out_word_t               out_word_r, out_word_nxt;

  logic                             accept;
  logic                             out_free;
  logic                             due;
  logic                             hit;
  logic                             take;
  logic                             earlier;
  logic                             adv;
  logic                             emit_mid;
  logic                             emit_fin;
  logic [CMPW-1:0]                  cnt_ext;
  logic [tst_pkg::SLOT_W-1:0]       cur_slot;
  logic [tst_pkg::TIME_W:0]         sum_full;
  tst_pkg::out_word_t               fin_word;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign cnt_ext  = CMPW'(cnt_r);
  assign cur_slot = cnt_ext[tst_pkg::SLOT_W-1:0];

  assign due     = head.active && (head.expiry <= now_r);
  assign hit     = (op_r == tst_pkg::OP_CANCEL) && head.active
                   && (cnt_ext == CMPW'(idx_r));
  assign take    = (op_r == tst_pkg::OP_SCHEDULE) && !found_r && !head.active;
  assign earlier = head.active && (!found_r || (head.expiry < min_r));

  assign adv      = !((op_r == tst_pkg::OP_FIRE) && due && pend_r && !out_free);
  assign shift    = (state_r == S_SCAN) && adv;
  assign emit_mid = (state_r == S_SCAN) && (op_r == tst_pkg::OP_FIRE) && due
                    && pend_r && out_free;
  assign emit_fin = (state_r == S_DONE) && out_free;

  assign sum_full = {1'b0, in_data.now_ms} + (tst_pkg::TIME_W + 1)'(in_data.delay_ms);

  always_comb begin
    tail = head;
    if (take) begin
      tail.active = 1'b1;
      tail.expiry = sum_r;
    end else if (hit || ((op_r == tst_pkg::OP_FIRE) && due)) begin
      tail.active = 1'b0;
    end
  end

  always_comb begin
    fin_word = '0;
    fin_word.last = 1'b1;
    case (op_r)
      tst_pkg::OP_SCHEDULE: begin
        fin_word.status = found_r ? tst_pkg::ST_OK : tst_pkg::ST_FULL;
        fin_word.slot   = found_r ? fslot_r : '0;
      end
      tst_pkg::OP_CANCEL: begin
        fin_word.status = found_r ? tst_pkg::ST_OK : tst_pkg::ST_NOT_FOUND;
        fin_word.slot   = idx_r;
      end
      tst_pkg::OP_QUERY: begin
        fin_word.status  = found_r ? tst_pkg::ST_OK : tst_pkg::ST_NO_TIMERS;
        fin_word.wait_ms = (found_r && (min_r > now_r)) ? (min_r - now_r) : '0;
      end
      tst_pkg::OP_FIRE: begin
        fin_word.status = pend_r ? tst_pkg::ST_OK : tst_pkg::ST_NONE_DUE;
        fin_word.slot   = pend_r ? pslot_r : '0;
      end
      default: begin
        fin_word.status = tst_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    if (emit_mid) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      out_word_nxt.status = tst_pkg::ST_OK;
      out_word_nxt.slot   = pslot_r;
    end else if (emit_fin) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = fin_word;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_SCAN;
      S_SCAN: if (shift && (cnt_r == LAST_STEP)) state_nxt = S_DONE;
      S_DONE: if (emit_fin) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (shift) begin
        cnt_r <= (cnt_r == LAST_STEP) ? '0 : cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (accept) begin
      op_r    <= in_data.operation;
      now_r   <= in_data.now_ms;
      idx_r   <= in_data.slot_index;
      sum_r   <= sum_full[tst_pkg::TIME_W] ? '1 : sum_full[tst_pkg::TIME_W-1:0];
      found_r <= 1'b0;
      pend_r  <= 1'b0;
      fslot_r <= '0;
      min_r   <= '0;
      pslot_r <= '0;
    end else if (shift) begin
      case (op_r)
        tst_pkg::OP_SCHEDULE: begin
          if (take) begin
            found_r <= 1'b1;
            fslot_r <= cur_slot;
          end
        end
        tst_pkg::OP_CANCEL: begin
          if (hit) found_r <= 1'b1;
        end
        tst_pkg::OP_QUERY: begin
          if (earlier) begin
            found_r <= 1'b1;
            min_r   <= head.expiry;
          end
        end
        tst_pkg::OP_FIRE: begin
          if (due) begin
            pend_r  <= 1'b1;
            pslot_r <= cur_slot;
          end
        end
        default: begin
          found_r <= found_r;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

FILE: hw/rtl/timer_slot_table.sv
// The input word is accepted only in the idle state; the slot ring is then scanned, and
// the result word is registered from the done state. No new input word is taken until
// then. Each item rotates the slot ring once through the head cell, one slot per cycle
// unless out_stall holds a word while the next is ready; that also holds the done state.
// Reset: synchronous, active low; clears all slot active bits and the control state.
module timer_slot_table #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tst_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tst_pkg::out_word_t out_data
);

  tst_pkg::slot_entry_t ring [SLOTS];
  tst_pkg::slot_entry_t tail;
  logic                 shift;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    tst_pkg::slot_entry_t d;
    if (k == SLOTS - 1) begin : g_end
      assign d = tail;
    end else begin : g_mid
      assign d = ring[k+1];
    end
    tst_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .d     (d),
      .q     (ring[k])
    );
  end

  tst_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head      (ring[0]),
    .tail      (tail),
    .shift     (shift)
  );

endmodule

FILE: bench/tb_timer_slot_table.sv
module tb_timer_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  import tst_pkg::*;

  localparam int NSLOTS = 16;
  localparam int HOLD_CYCLES = 300;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  // predicted table contents, updated as each word is accepted
  logic [NSLOTS-1:0] slot_armed = '0;
  logic [TIME_W-1:0] slot_due [NSLOTS];
  out_word_t         pending_results [$];
  logic [TIME_W-1:0] clock_ms = '0;

  int mismatches = 0;
  bit sender_gaps = 1'b1;
  bit hold_req = 1'b0;
  bit quiet_tail = 1'b0;

  timer_slot_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

  function automatic in_word_t timer_cmd(input logic [1:0] op, input logic [TIME_W-1:0] now,
                                         input logic [DELAY_W-1:0] delay,
                                         input logic [SLOT_W-1:0] idx);
    in_word_t w;
    w.operation = op;
    w.now_ms = now;
    w.delay_ms = delay;
    w.slot_index = idx;
    return w;
  endfunction

  function automatic void apply_to_table(input in_word_t w);
    out_word_t         r;
    out_word_t         prev;
    bit                have_prev;
    bit                found;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] earliest;
    r = '0;
    r.last = 1'b1;
    have_prev = 1'b0;
    found = 1'b0;
    earliest = '0;
    case (w.operation)
      OP_SCHEDULE: begin
        r.status = ST_FULL;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!slot_armed[i]) begin
            sum = {1'b0, w.now_ms} + (TIME_W+1)'(w.delay_ms);
            slot_due[i] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            slot_armed[i] = 1'b1;
            r.status = ST_OK;
            r.slot = SLOT_W'(i);
            break;
          end
        end
        pending_results.push_back(r);
      end
      OP_CANCEL: begin
        r.slot = w.slot_index;
        if (slot_armed[w.slot_index]) begin
          slot_armed[w.slot_index] = 1'b0;
          r.status = ST_OK;
        end else begin
          r.status = ST_NOT_FOUND;
        end
        pending_results.push_back(r);
      end
      OP_QUERY: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (slot_armed[i] && (!found || slot_due[i] < earliest)) begin
            earliest = slot_due[i];
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_NO_TIMERS;
        end else begin
          r.status = ST_OK;
          r.wait_ms = (earliest > w.now_ms) ? earliest - w.now_ms : '0;
        end
        pending_results.push_back(r);
      end
      OP_FIRE: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (slot_armed[i] && slot_due[i] <= w.now_ms) begin
            slot_armed[i] = 1'b0;
            if (have_prev) pending_results.push_back(prev);
            prev = '0;
            prev.status = ST_OK;
            prev.slot = SLOT_W'(i);
            have_prev = 1'b1;
          end
        end
        if (have_prev) begin
          prev.last = 1'b1;
          pending_results.push_back(prev);
        end else begin
          r.status = ST_NONE_DUE;
          pending_results.push_back(r);
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string field, input logic [TIME_W-1:0] want,
                                      input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", TIME_W'(want.status), TIME_W'(out_data.status));
        check_field("slot", TIME_W'(want.slot), TIME_W'(out_data.slot));
        check_field("wait_ms", want.wait_ms, out_data.wait_ms);
        check_field("last", TIME_W'(want.last), TIME_W'(out_data.last));
      end
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input in_word_t w);
    if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_to_table(w);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_word(timer_cmd(OP_QUERY, '0, '1, '1));
    send_word(timer_cmd(OP_FIRE, TIME_MAX, '0, '0));
  endtask

  task automatic test_expiry_edges();
    send_word(timer_cmd(OP_SCHEDULE, '0, '0, '0));
    // sum overflows the time range and saturates
    send_word(timer_cmd(OP_SCHEDULE, TIME_MAX, '1, '0));
    send_word(timer_cmd(OP_SCHEDULE, 48'hFFFF_0000_0000, '1, '1));
    send_word(timer_cmd(OP_QUERY, '0, '0, '0));
    send_word(timer_cmd(OP_FIRE, '0, '0, '0));
    send_word(timer_cmd(OP_QUERY, 48'd5, '0, '0));
    send_word(timer_cmd(OP_CANCEL, '0, '0, 4'd1));
    send_word(timer_cmd(OP_CANCEL, '0, '0, 4'd1));
    send_word(timer_cmd(OP_FIRE, TIME_MAX, '0, '0));
  endtask

  task automatic test_full_table();
    logic [DELAY_W-1:0] delay;
    for (int i = 0; i < NSLOTS; i++) begin
      delay = i[0] ? 32'h8000_0000 + DELAY_W'(i) : DELAY_W'(i);
      send_word(timer_cmd(OP_SCHEDULE, 48'd1000, delay, '0));
    end
    send_word(timer_cmd(OP_SCHEDULE, 48'd1000, 32'd1, '0));
    send_word(timer_cmd(OP_FIRE, TIME_MAX, '0, '0));
  endtask

  task automatic test_random_traffic(input int count);
    int                 sel;
    logic [1:0]         op;
    logic [DELAY_W-1:0] delay;
    logic [SLOT_W-1:0]  idx;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) clock_ms = TIME_W'({$urandom, $urandom});
      else if (sel == 1) clock_ms = TIME_MAX - $urandom_range(0, 100);
      else clock_ms = clock_ms + $urandom_range(0, 40);
      sel = $urandom_range(0, 9);
      if (sel == 0) delay = $urandom;
      else if (sel == 1) delay = '0;
      else delay = $urandom_range(1, 120);
      idx = SLOT_W'($urandom_range(0, NSLOTS - 1));
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        op = OP_SCHEDULE;
      end else if (sel < 55) begin
        op = OP_CANCEL;
        // mostly aim at a live slot
        if ($urandom_range(0, 3) != 0) begin
          for (int k = 0; k < NSLOTS && !slot_armed[idx]; k++) idx = idx + 1'b1;
        end
      end else if (sel < 70) begin
        op = OP_QUERY;
      end else begin
        op = OP_FIRE;
      end
      send_word(timer_cmd(op, clock_ms, delay, idx));
    end
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_req <= 1'b1;
    test_random_traffic(24);
    drain_results();
    sender_gaps = 1'b1;
  endtask

  task automatic test_quiet_tail();
    quiet_tail <= 1'b1;
    test_random_traffic(40);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_expiry_edges();
    test_full_table();
    test_random_traffic(330);
    test_backpressure();
    test_quiet_tail();
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tst_pkg.sv
hw/rtl/tst_cell.sv
hw/rtl/tst_seq.sv
hw/rtl/timer_slot_table.sv
bench/tb_timer_slot_table.sv
